// File: hdl/c_escape_sequence_decoder_core_macros.svh
// Assertion macros shared by the escape decoder modules.
`ifndef C_ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CESD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cesd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CESD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cesd assertion failed");

`endif

// File: hdl/cesd_pkg.sv
// Types, character constants and helpers of the escape sequence decoder.
package cesd_pkg;

    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_LX    = 8'h78;
    localparam logic [7:0] C_UX    = 8'h58;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_EIGHT = 8'h38;

    localparam int unsigned REC_BYTES = 5;
    localparam int unsigned HELD_DEPTH = 4;

    typedef enum logic [4:0] {
        PH_PLAIN = 5'b00001,
        PH_BSL   = 5'b00010,
        PH_HEXX  = 5'b00100,
        PH_OCT   = 5'b01000,
        PH_HEX   = 5'b10000
    } t_phase;

    // One record holds every byte that a single input byte releases.
    typedef struct packed {
        logic [REC_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      last;
    } t_rec;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= C_ZERO) && (c < C_EIGHT);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d = c - 8'h30;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            d = c - 8'h57;
        end else begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    // A value decodes when it is above ASCII or a printable character.
    function automatic logic decodes(input logic [8:0] v);
        return (v[8:7] != 2'b00) || ((v >= 9'h020) && (v <= 9'h07E));
    endfunction

endpackage

// File: hdl/cesd_if.sv
// Valid/ready channel interfaces for the input and output byte streams.
interface cesd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface cesd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hdl/cesd_front.sv
// Front end: scans input bytes and turns each into a record of output bytes.
module cesd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cesd_in_if.sink       i_in,
    input  logic          i_full,
    output logic          o_push,
    output cesd_pkg::t_rec o_rec
);
    import cesd_pkg::*;

    t_phase                     r_phase, n_phase;
    logic [HELD_DEPTH-1:0][7:0] r_held, n_held;
    logic [2:0]                 r_hc, n_hc;
    logic [1:0]                 r_dc, n_dc;
    logic [8:0]                 r_val, n_val;

    logic       w_fire;
    logic [7:0] w_c;
    logic       w_last;
    t_rec       w_rec;

    assign i_in.ready = !i_full;
    assign w_fire     = i_in.valid && !i_full;
    assign w_c        = i_in.in_byte;
    assign w_last     = i_in.in_last;

    always_comb begin
        logic [HELD_DEPTH-1:0][7:0] hold_b, s_held;
        logic [2:0]                 hold_hc, s_hc;
        logic [8:0]                 s_val;
        logic                       do_pair, do_flush, do_settle, do_fresh;
        logic [2:0]                 e_n;

        hold_b = r_held;
        hold_hc = r_hc;
        if (r_hc < 3'(HELD_DEPTH)) begin
            hold_b[r_hc[1:0]] = w_c;
            hold_hc = r_hc + 3'd1;
        end

        n_phase = r_phase;
        n_held  = r_held;
        n_hc    = r_hc;
        n_dc    = r_dc;
        n_val   = r_val;
        s_held  = r_held;
        s_hc    = r_hc;
        s_val   = r_val;
        do_pair = 1'b0;
        do_flush = 1'b0;
        do_settle = 1'b0;
        do_fresh = 1'b0;

        unique case (r_phase)
            PH_BSL: begin
                if (is_oct(w_c)) begin
                    n_held  = hold_b;
                    n_hc    = hold_hc;
                    n_val   = {6'b0, 3'(w_c - C_ZERO)};
                    n_dc    = 2'd1;
                    n_phase = PH_OCT;
                    do_settle = w_last;
                end else if (((w_c == C_LX) || (w_c == C_UX)) && !w_last) begin
                    n_held  = hold_b;
                    n_hc    = hold_hc;
                    n_phase = PH_HEXX;
                end else begin
                    do_pair = 1'b1;
                end
            end
            PH_HEXX: begin
                if (is_hex(w_c)) begin
                    n_held  = hold_b;
                    n_hc    = hold_hc;
                    n_val   = {5'b0, hex_val(w_c)};
                    n_dc    = 2'd1;
                    n_phase = PH_HEX;
                    do_settle = w_last;
                end else begin
                    do_flush = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            PH_OCT: begin
                if (is_oct(w_c)) begin
                    n_held  = hold_b;
                    n_hc    = hold_hc;
                    n_val   = {r_val[5:0], 3'b000} + {6'b0, 3'(w_c - C_ZERO)};
                    n_dc    = r_dc + 2'd1;
                    do_settle = (n_dc == 2'd3) || w_last;
                end else begin
                    do_settle = 1'b1;
                    do_fresh  = 1'b1;
                end
            end
            PH_HEX: begin
                if (is_hex(w_c)) begin
                    n_held  = hold_b;
                    n_hc    = hold_hc;
                    n_val   = {r_val[4:0], 4'b0000} + {5'b0, hex_val(w_c)};
                    n_dc    = r_dc + 2'd1;
                    do_settle = (n_dc == 2'd2) || w_last;
                end else begin
                    do_settle = 1'b1;
                    do_fresh  = 1'b1;
                end
            end
            default: begin
                n_hc    = 3'd0;
                n_dc    = 2'd0;
                n_val   = 9'd0;
                n_phase = PH_PLAIN;
                do_fresh = 1'b1;
            end
        endcase

        // A settle on a digit just taken sees the escape including that digit.
        if (do_settle && (n_hc != r_hc)) begin
            s_held = n_held;
            s_hc   = n_hc;
            s_val  = n_val;
        end

        w_rec = '0;
        e_n = 3'd0;
        if (do_pair) begin
            w_rec.bytes[e_n] = C_BSL;
            e_n = e_n + 3'd1;
            w_rec.bytes[e_n] = w_c;
            e_n = e_n + 3'd1;
        end
        if (do_settle && decodes(s_val)) begin
            w_rec.bytes[e_n] = s_val[7:0];
            e_n = e_n + 3'd1;
        end else if (do_flush || do_settle) begin
            for (int k = 0; k < HELD_DEPTH; k++) begin
                if (3'(k) < s_hc) begin
                    w_rec.bytes[e_n] = s_held[2'(k)];
                    e_n = e_n + 3'd1;
                end
            end
        end

        if (do_pair || do_flush || do_settle) begin
            n_hc    = 3'd0;
            n_dc    = 2'd0;
            n_val   = 9'd0;
            n_phase = PH_PLAIN;
        end
        if (do_fresh) begin
            if ((w_c == C_BSL) && !w_last) begin
                n_held[0] = C_BSL;
                n_hc      = 3'd1;
                n_phase   = PH_BSL;
            end else begin
                w_rec.bytes[e_n] = w_c;
                e_n = e_n + 3'd1;
            end
        end
        if (w_last) begin
            n_hc    = 3'd0;
            n_dc    = 2'd0;
            n_val   = 9'd0;
            n_phase = PH_PLAIN;
        end
        w_rec.cnt  = e_n;
        w_rec.last = w_last;
    end

    assign o_push = w_fire && (w_rec.cnt != 3'd0);
    assign o_rec  = w_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_hc    <= 3'd0;
            r_dc    <= 2'd0;
            r_val   <= 9'd0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_hc    <= n_hc;
            r_dc    <= n_dc;
            r_val   <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_held <= n_held;
        end
    end

endmodule

// File: hdl/cesd_queue.sv
// Short record queue between the scanning front end and the byte sender.
`include "c_escape_sequence_decoder_core_macros.svh"

module cesd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cesd_pkg::t_rec i_rec,
    output logic           o_full,
    output logic           o_valid,
    output cesd_pkg::t_rec o_head,
    input  logic           i_pop
);
    import cesd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    `CESD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `CESD_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid)
    `CESD_ASSERT_NEXT(a_cnt_grows, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + CW'(1))

endmodule

// File: hdl/cesd_back.sv
// Back end: sends record bytes one per cycle unless stalled.
`include "c_escape_sequence_decoder_core_macros.svh"

module cesd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cesd_pkg::t_rec i_head,
    output logic           o_pop,
    cesd_out_if.source     o_out
);
    import cesd_pkg::*;

    logic [2:0] r_idx;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;

    logic w_load;
    logic w_final;

    assign w_load  = i_valid && (!r_ov || o_out.ready);
    assign w_final = (r_idx == (i_head.cnt - 3'd1));
    assign o_pop   = w_load && w_final;

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.out_last = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_ov  <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov  <= 1'b1;
                r_idx <= w_final ? 3'd0 : r_idx + 3'd1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ob <= i_head.bytes[r_idx];
            r_ol <= i_head.last && w_final;
        end
    end

    `CESD_ASSERT_NOW(a_idx_in_rec, i_clk, i_rst_n, i_valid, r_idx < i_head.cnt)
    `CESD_ASSERT_NEXT(a_last_sent, i_clk, i_rst_n, o_pop && i_head.last, r_ov && r_ol)
    `CESD_ASSERT_NOW(a_idx_idle, i_clk, i_rst_n, !i_valid, r_idx == 3'd0)

endmodule

// File: hdl/c_escape_sequence_decoder_core.sv
// Top level of the C string escape sequence decoder.
//
//   channel  dir  payload              handshake
//   i_in     in   in_byte, in_last     valid/ready, taken when both high
//   o_out    out  out_byte, out_last   valid/ready, taken when both high
//
// The front end takes one input byte per cycle whenever the record queue has room.
// Each input byte releases zero to four output bytes, sent one per cycle from
// the back end while o_out is ready; the single output register sets that rate.
// A byte that releases nothing (a held escape byte) pushes no record to the queue.
// Reset is synchronous, active low, and returns the scanner to plain text.
// Output stalls fill the queue, after which input ready drops.
module c_escape_sequence_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cesd_in_if.sink    i_in,
    cesd_out_if.source o_out
);
    import cesd_pkg::*;

    logic w_push, w_full, w_valid, w_pop;
    t_rec w_rec, w_head;

    cesd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_rec)
    );

    cesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    cesd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// File: bench/tb_c_escape_sequence_decoder_core.sv
// Self-checking bench for the C string escape decoder: byte streams in, unescaped bytes checked.
`timescale 1ns / 100ps

module tb_c_escape_sequence_decoder_core;
    import cesd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_BYTES = 410;

    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_LOW_A = 8'h61;
    localparam logic [7:0] C_LOW_F = 8'h66;
    localparam logic [7:0] C_UP_A  = 8'h41;
    localparam logic [7:0] C_UP_F  = 8'h46;
    localparam logic [7:0] C_LOW_G = 8'h67;
    localparam logic [7:0] C_LOW_Z = 8'h7A;

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } t_str_byte;

    logic i_clk;
    logic i_rst_n;

    cesd_in_if  in_if ();
    cesd_out_if out_if ();

    c_escape_sequence_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Stimulus and expected output streams.
    t_str_byte   pending_bytes[$];
    t_str_byte   expected_bytes[$];
    t_str_byte   step_bytes[$];
    int unsigned total_bytes;
    int unsigned accepted_cnt;
    int unsigned err_cnt;
    int unsigned cycle_cnt;

    // Decoder state kept by the bench.
    logic [7:0]  esc_held[4];
    int unsigned esc_held_n;
    t_phase      scan_ph;
    int unsigned esc_digits;
    logic [8:0]  esc_val;

    // Handshake bookkeeping of the clocked blocks; in_taken is shared by driver and monitor.
    bit          in_taken;
    int unsigned in_gap;
    int unsigned out_stall;
    bit          in_calm;
    bit          out_calm;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        if (step_bytes.size() < 5) begin
            step_bytes.push_back('{value: b, fin: 1'b0});
        end
    endfunction

    function automatic void back_to_plain();
        esc_held_n = 0;
        esc_digits = 0;
        esc_val = '0;
        scan_ph = PH_PLAIN;
    endfunction

    function automatic void keep_byte(input logic [7:0] b);
        if (esc_held_n < 4) begin
            esc_held[esc_held_n] = b;
            esc_held_n++;
        end
    endfunction

    function automatic void release_held();
        for (int unsigned k = 0; k < esc_held_n; k++) begin
            put_byte(esc_held[k]);
        end
        back_to_plain();
    endfunction

    function automatic bit octal_digit(input logic [7:0] c);
        return (c >= C_ZERO) && (c < C_EIGHT);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= C_ZERO && c <= C_NINE) begin
            return int'(c - C_ZERO);
        end else if (c >= C_LOW_A && c <= C_LOW_F) begin
            return int'(c - C_LOW_A) + 10;
        end else if (c >= C_UP_A && c <= C_UP_F) begin
            return int'(c - C_UP_A) + 10;
        end
        return -1;
    endfunction

    // Values above ASCII or printable are replaced; anything else goes out as written.
    function automatic void settle_escape();
        if (esc_val >= 9'd128 || (esc_val >= 9'h020 && esc_val <= 9'h07E)) begin
            put_byte(esc_val[7:0]);
            back_to_plain();
        end else begin
            release_held();
        end
    endfunction

    function automatic void plain_byte(input logic [7:0] c, input logic last);
        if (c == C_BSL && !last) begin
            back_to_plain();
            keep_byte(c);
            scan_ph = PH_BSL;
        end else begin
            put_byte(c);
        end
    endfunction

    function automatic void predict_unescape(input logic [7:0] c, input logic last);
        int h;
        step_bytes.delete();
        h = hex_digit(c);
        case (scan_ph)
            PH_BSL: begin
                if (octal_digit(c)) begin
                    keep_byte(c);
                    esc_val = 9'(c - C_ZERO);
                    esc_digits = 1;
                    scan_ph = PH_OCT;
                    if (last) begin
                        settle_escape();
                    end
                end else if ((c == C_LX || c == C_UX) && !last) begin
                    keep_byte(c);
                    scan_ph = PH_HEXX;
                end else begin
                    put_byte(C_BSL);
                    put_byte(c);
                    back_to_plain();
                end
            end
            PH_HEXX: begin
                if (h >= 0) begin
                    keep_byte(c);
                    esc_val = 9'(h);
                    esc_digits = 1;
                    scan_ph = PH_HEX;
                    if (last) begin
                        settle_escape();
                    end
                end else begin
                    release_held();
                    plain_byte(c, last);
                end
            end
            PH_OCT: begin
                if (octal_digit(c)) begin
                    keep_byte(c);
                    esc_val = (esc_val << 3) + 9'(c - C_ZERO);
                    esc_digits++;
                    if (esc_digits >= 3 || last) begin
                        settle_escape();
                    end
                end else begin
                    settle_escape();
                    plain_byte(c, last);
                end
            end
            PH_HEX: begin
                if (h >= 0) begin
                    keep_byte(c);
                    esc_val = (esc_val << 4) + 9'(h);
                    esc_digits++;
                    if (esc_digits >= 2 || last) begin
                        settle_escape();
                    end
                end else begin
                    settle_escape();
                    plain_byte(c, last);
                end
            end
            default: begin
                back_to_plain();
                plain_byte(c, last);
            end
        endcase
        if (last) begin
            back_to_plain();
            if (step_bytes.size() > 0) begin
                step_bytes[step_bytes.size() - 1].fin = 1'b1;
            end
        end
        foreach (step_bytes[k]) begin
            expected_bytes.push_back(step_bytes[k]);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_cnt < 100) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back('{value: b, fin: last});
    endfunction

    function automatic void queue_text(input string s, input logic ends);
        for (int k = 0; k < s.len(); k++) begin
            queue_byte(s[k], ends && (k == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return C_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) ? C_LOW_A : C_UP_A) + 8'(v - 10);
    endfunction

    // One body is a run of tokens: mostly well-formed escapes and text, some broken escapes.
    function automatic void queue_random_body();
        logic [7:0]  body[$];
        int unsigned tokens;
        int unsigned r;
        int unsigned n;
        tokens = $urandom_range(1, 6);
        for (int unsigned t = 0; t < tokens; t++) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                body.push_back(8'($urandom_range(32, 126)));
            end else if (r < 34) begin
                body.push_back(8'($urandom_range(0, 255)));
            end else if (r < 56) begin
                body.push_back(C_BSL);
                n = $urandom_range(1, 3);
                for (int unsigned d = 0; d < n; d++) begin
                    body.push_back(C_ZERO + 8'($urandom_range(0, 7)));
                end
            end else if (r < 76) begin
                body.push_back(C_BSL);
                body.push_back($urandom_range(0, 1) ? C_LX : C_UX);
                n = $urandom_range(1, 2);
                for (int unsigned d = 0; d < n; d++) begin
                    body.push_back(rand_hex_char());
                end
            end else if (r < 86) begin
                body.push_back(C_BSL);
                body.push_back(8'($urandom_range(0, 255)));
            end else if (r < 93) begin
                body.push_back(C_BSL);
                body.push_back($urandom_range(0, 1) ? C_LX : C_UX);
                body.push_back(8'($urandom_range(C_LOW_G, C_LOW_Z)));
            end else begin
                body.push_back(C_BSL);
            end
        end
        foreach (body[k]) begin
            queue_byte(body[k], k == body.size() - 1);
        end
    endfunction

    // Driver: the input request changes only at the falling edge.
    always @(negedge i_clk) begin
        t_str_byte item;
        if (cycle_cnt % 128 == 0) begin
            in_calm = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
        end
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!(in_if.valid && !in_taken)) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                item = pending_bytes.pop_front();
                in_if.valid <= 1'b1;
                in_if.in_byte <= item.value;
                in_if.in_last <= item.fin;
                in_gap = pick_gap(in_calm);
            end else begin
                in_if.valid <= 1'b0;
            end
        end

        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            out_stall = pick_gap(out_calm);
        end
    end

    // Monitor: requests taken at the rising edge are predicted first, then results checked.
    always @(posedge i_clk) begin
        t_str_byte want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_c_escape_sequence_decoder_core: done, errors");
            $finish;
        end else if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_unescape(in_if.in_byte, in_if.in_last);
                accepted_cnt++;
                in_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              out_if.out_byte, out_if.out_last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_if.out_byte !== want.value) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_if.out_byte, want.value));
                    end
                    if (out_if.out_last !== want.fin) begin
                        report_mismatch($sformatf("out_last %0b, expected %0b on byte %02h",
                                                  out_if.out_last, want.fin, want.value));
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        out_if.ready = 1'b0;
        cycle_cnt = 0;
        accepted_cnt = 0;
        err_cnt = 0;
        in_taken = 1'b0;
        in_gap = 0;
        out_stall = 0;
        in_calm = 1'b0;
        out_calm = 1'b0;
        back_to_plain();

        // Directed bodies: octal wrap above 255, non-printable hex, broken hex,
        // other pair, byte extremes, trailing backslash, then short bodies that end
        // right after x, inside an octal escape and on a complete hex escape.
        queue_text("\\777\\x4g\\Xz\\q", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(C_BSL, 1'b1);
        queue_text("\\x", 1'b1);
        queue_text("\\12", 1'b1);
        queue_text("\\x41", 1'b1);
        while (pending_bytes.size() < 25 + RANDOM_BYTES) begin
            queue_random_body();
        end
        total_bytes = pending_bytes.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt != total_bytes || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_c_escape_sequence_decoder_core: done, clean");
        end else begin
            $display("tb_c_escape_sequence_decoder_core: done, errors");
        end
        $finish;
    end

endmodule
